// ===== hw/rtl/qsaa_pkg.sv =====
package qsaa_pkg;

    localparam int LEVELS     = 7;
    localparam int TOP_LEVEL  = 6;
    localparam int MAX_CLASS  = 4;
    localparam int MIN_SLOT   = 32;
    localparam int LIST_DEPTH = 4;
    localparam int BLOCK      = 2048;

    localparam int LVL_W   = 3;
    localparam int POS_W   = 2;
    localparam int CNT_W   = 3;
    localparam int SIDE_W  = 16;
    localparam int COORD_W = 12;
    localparam int SLOT_W  = 13;
    localparam int ENTRY_W = 2 * COORD_W;

    // The top level is never pushed to, so only the lower six levels need storage
    localparam int RAM_DEPTH = TOP_LEVEL * LIST_DEPTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef logic [LVL_W-1:0]   lvl_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [1:0] {
        ST_GRANTED    = 2'd0,
        ST_TOO_BIG    = 2'd1,
        ST_NO_SPACE   = 2'd2,
        ST_RESET_DONE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CLASS,
        S_FETCH,
        S_SPLIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    atlas_rst;
        logic    take;
        logic    fetch;
        logic    split;
        logic    res_load;
        status_t res_code;
        logic    set_pending;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic reset_req;
        logic pending;
        logic too_big;
        logic no_space;
        logic at_class;
        logic last_quarter;
    } stat_t;

    function automatic coord_t slot_size(input lvl_t lvl);
        return coord_t'(MIN_SLOT) << lvl;
    endfunction

    // Corners of the top-level blocks in load order, entry is {y, x}
    function automatic entry_t top_block(input pos_t pos);
        entry_t e;
        case (pos)
            2'd0:    e = {coord_t'(0), coord_t'(0)};
            2'd1:    e = {coord_t'(BLOCK), coord_t'(BLOCK)};
            2'd2:    e = {coord_t'(0), coord_t'(BLOCK)};
            2'd3:    e = {coord_t'(BLOCK), coord_t'(0)};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ===== hw/rtl/qsaa_ram.sv =====
module qsaa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/qsaa_ctrl.sv =====
module qsaa_ctrl
    import qsaa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = ST_GRANTED;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                if (stat.reset_req)
                begin
                    cmd.atlas_rst = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_code  = ST_RESET_DONE;
                    state_next    = S_DONE;
                end
                else
                begin
                    // restore the atlas after the last request refused for lack of space
                    cmd.atlas_rst = stat.pending;
                    state_next    = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (stat.too_big)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_TOO_BIG;
                    state_next   = S_DONE;
                end
                else if (stat.no_space)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_code    = ST_NO_SPACE;
                    cmd.set_pending = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.take   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (stat.at_class)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_GRANTED;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                cmd.split = 1'b1;
                if (stat.last_quarter && stat.at_class)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_GRANTED;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/qsaa_datapath.sv =====
module qsaa_datapath
    import qsaa_pkg::*;
#(
    parameter int MAX_ATLAS = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  logic                     cfg_big,
    input  logic                     req_type,
    input  logic [SIDE_W-1:0]        req_width,
    input  logic [SIDE_W-1:0]        req_height,
    output logic                     granted,
    output logic signed [SLOT_W-1:0] slot_x,
    output logic signed [SLOT_W-1:0] slot_y,
    output logic [1:0]               status
);

    localparam int   BLOCKS_PER_SIDE = (MAX_ATLAS + BLOCK - 1) / BLOCK;
    localparam cnt_t TOP_BLOCKS      = cnt_t'(BLOCKS_PER_SIDE * BLOCKS_PER_SIDE);

    logic              type_reg;
    logic [SIDE_W-1:0] w_reg, h_reg;
    cnt_t              cnt_reg  [LEVELS];
    cnt_t              cnt_next [LEVELS];
    pos_t              head_reg [LEVELS];
    pos_t              head_next[LEVELS];
    logic              pending_reg, big_reg;
    lvl_t              lvl_reg;
    pos_t              k_reg;
    coord_t            x_reg, y_reg;
    logic              top_reg;
    status_t           code_reg;

    logic              granted_reg;
    logic [SLOT_W-1:0] slot_x_reg, slot_y_reg;
    status_t           status_reg;

    logic [SIDE_W-1:0] side;
    lvl_t              cls, src;
    logic              cls_ovf, found;
    coord_t            s;
    entry_t            wr_data, rd_data, top_entry;
    logic [RAM_AW-1:0] wr_addr, rd_addr;
    pos_t              wr_pos;

    // Class from the larger side: the smallest level whose slot covers it
    always_comb
    begin
        side    = (w_reg > h_reg) ? w_reg : h_reg;
        cls     = lvl_t'(TOP_LEVEL);
        cls_ovf = 1'b1;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (side <= (SIDE_W'(MIN_SLOT) << l))
            begin
                cls     = lvl_t'(l);
                cls_ovf = 1'b0;
            end
        end
    end

    // First non-empty level at or above the class
    always_comb
    begin
        src   = lvl_t'(TOP_LEVEL);
        found = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (lvl_t'(l) >= cls && cnt_reg[l] != '0)
            begin
                src   = lvl_t'(l);
                found = 1'b1;
            end
        end
    end

    assign stat.reset_req    = type_reg;
    assign stat.pending      = pending_reg;
    assign stat.too_big      = cls_ovf || (cls > lvl_t'(MAX_CLASS))
                               || (cls == lvl_t'(MAX_CLASS) && !big_reg);
    assign stat.no_space     = !found;
    assign stat.at_class     = (lvl_reg == cls);
    assign stat.last_quarter = (k_reg == pos_t'(LIST_DEPTH - 1));

    assign top_entry = top_block(head_reg[TOP_LEVEL]);
    assign rd_addr   = {src, head_reg[src]};

    // Quarters after the first: the first keeps the corner and is popped at once
    always_comb
    begin
        s       = slot_size(lvl_reg);
        wr_pos  = head_reg[lvl_reg] + k_reg;
        wr_addr = {lvl_reg, wr_pos};
        unique case (k_reg)
            2'd1:    wr_data = {y_reg + s, x_reg};
            2'd2:    wr_data = {y_reg, x_reg + s};
            2'd3:    wr_data = {y_reg + s, x_reg + s};
            default: wr_data = {y_reg, x_reg};
        endcase
    end

    qsaa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RAM_DEPTH)
    ) u_slots (
        .clk    (clk),
        .wr_en  (cmd.split),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            cnt_next[l]  = cnt_reg[l];
            head_next[l] = head_reg[l];
        end
        if (cmd.atlas_rst)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                cnt_next[l]  = '0;
                head_next[l] = '0;
            end
            cnt_next[TOP_LEVEL] = cfg_big ? TOP_BLOCKS : cnt_t'(1);
        end
        if (cmd.take)
        begin
            cnt_next[src]  = cnt_reg[src] - cnt_t'(1);
            head_next[src] = head_reg[src] + pos_t'(1);
        end
        if (cmd.split && stat.last_quarter)
        begin
            cnt_next[lvl_reg]  = cnt_t'(LIST_DEPTH - 1);
            head_next[lvl_reg] = head_reg[lvl_reg] + pos_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                cnt_reg[l]  <= (l == TOP_LEVEL) ? TOP_BLOCKS : '0;
                head_reg[l] <= '0;
            end
            pending_reg <= 1'b0;
            big_reg     <= 1'b1;
            type_reg    <= 1'b0;
            lvl_reg     <= '0;
            k_reg       <= '0;
            top_reg     <= 1'b0;
            code_reg    <= ST_GRANTED;
        end
        else
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                cnt_reg[l]  <= cnt_next[l];
                head_reg[l] <= head_next[l];
            end
            if (cmd.capture)
            begin
                type_reg <= req_type;
            end
            if (cmd.atlas_rst)
            begin
                pending_reg <= 1'b0;
                big_reg     <= cfg_big;
            end
            else if (cmd.set_pending)
            begin
                pending_reg <= 1'b1;
            end
            if (cmd.res_load)
            begin
                code_reg <= cmd.res_code;
            end
            if (cmd.take)
            begin
                lvl_reg <= src;
                top_reg <= (src == lvl_t'(TOP_LEVEL));
            end
            if (cmd.fetch && !stat.at_class)
            begin
                lvl_reg <= lvl_reg - lvl_t'(1);
                k_reg   <= pos_t'(1);
            end
            if (cmd.split)
            begin
                if (stat.last_quarter)
                begin
                    k_reg <= pos_t'(1);
                    if (!stat.at_class)
                    begin
                        lvl_reg <= lvl_reg - lvl_t'(1);
                    end
                end
                else
                begin
                    k_reg <= k_reg + pos_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            w_reg <= req_width;
            h_reg <= req_height;
        end
        if (cmd.take && src == lvl_t'(TOP_LEVEL))
        begin
            x_reg <= top_entry[COORD_W-1:0];
            y_reg <= top_entry[ENTRY_W-1:COORD_W];
        end
        if (cmd.fetch && !top_reg)
        begin
            x_reg <= rd_data[COORD_W-1:0];
            y_reg <= rd_data[ENTRY_W-1:COORD_W];
        end
        if (cmd.out_load)
        begin
            granted_reg <= (code_reg == ST_GRANTED);
            status_reg  <= code_reg;
            slot_x_reg  <= (code_reg == ST_GRANTED) ? {1'b0, x_reg} : '1;
            slot_y_reg  <= (code_reg == ST_GRANTED) ? {1'b0, y_reg} : '1;
        end
    end

    assign granted = granted_reg;
    assign slot_x  = $signed(slot_x_reg);
    assign slot_y  = $signed(slot_y_reg);
    assign status  = status_reg;

endmodule

// ===== hw/rtl/quad_split_atlas_allocator.sv =====
// Square-slot allocator for a texture atlas of 4096 or 2048 pixels (atlas_is_4096,
// taken whenever the atlas is reset). Requests are classed by their larger side into
// slots of 32 to 512 pixels; an empty class takes the front slot of the next larger
// non-empty class and splits it down, writing three quarters per level into the
// free-slot memory one per cycle. A granted word splits from 0 to 6 levels. The
// result sits in an output register and the next word is accepted the cycle after it
// is loaded there. One word is worked on at a time. A request refused for lack of
// space marks the atlas for reset, which the next allocate request performs first.
module quad_split_atlas_allocator
    import qsaa_pkg::*;
#(
    parameter int MAX_ATLAS = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic [SIDE_W-1:0]        req_width,
    input  logic [SIDE_W-1:0]        req_height,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     granted,
    output logic signed [SLOT_W-1:0] slot_x,
    output logic signed [SLOT_W-1:0] slot_y,
    output logic [1:0]               status,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     atlas_is_4096
);

    cmd_t  cmd;
    stat_t stat;
    logic  big_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_cfg_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            big_cfg_reg <= atlas_is_4096;
        end
    end

    qsaa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qsaa_datapath #(
        .MAX_ATLAS(MAX_ATLAS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_big   (big_cfg_reg),
        .req_type  (req_type),
        .req_width (req_width),
        .req_height(req_height),
        .granted   (granted),
        .slot_x    (slot_x),
        .slot_y    (slot_y),
        .status    (status)
    );

endmodule

// ===== hw/rtl/qsaa_checker.sv =====
module qsaa_checker
    import qsaa_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     granted,
    input logic signed [SLOT_W-1:0] slot_x,
    input logic signed [SLOT_W-1:0] slot_y,
    input logic [1:0]               status
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(granted) && $stable(slot_x) && $stable(slot_y) && $stable(status))
        else $error("result word changed while stalled");

    a_grant_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (granted == (status == ST_GRANTED)))
        else $error("granted disagrees with status");

    a_refused_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> slot_x == '1 && slot_y == '1)
        else $error("refused word carries a slot");

    // slots are corners of the 32 pixel grid inside the atlas
    a_slot_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted |-> !slot_x[SLOT_W-1] && !slot_y[SLOT_W-1]
            && slot_x[4:0] == 5'd0 && slot_y[4:0] == 5'd0)
        else $error("granted slot off the grid");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in work");

endmodule

bind quad_split_atlas_allocator qsaa_checker u_qsaa_checker (.*);
